FILE: hw/rtl/frd_pkg.sv
// Package for the file response deframer: phase and status codes, marker tables,
// and the state and result structs shared by the step logic and the top level.
// No dependencies.
package frd_pkg;

    localparam logic OP_ARM = 1'b1;

    localparam int unsigned OK_LEN  = 5;
    localparam int unsigned ERR_LEN = 6;
    localparam int unsigned FIELD_BYTES = 4;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_OK      = 3'd1,
        PH_SIZE    = 3'd2,
        PH_STAMP   = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_ERROR   = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        ST_TAKEN   = 2'd0,
        ST_PAYLOAD = 2'd1,
        ST_ERRDONE = 2'd2,
        ST_PROTO   = 2'd3
    } status_t;

    typedef struct packed {
        phase_t      phase;
        logic [2:0]  match_pos;
        logic [1:0]  field_count;
        logic [31:0] remaining;
        logic [31:0] size;
        logic [31:0] stamp;
        logic [31:0] field_acc;
    } frd_state_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  payload_byte;
        logic        file_done;
        logic [31:0] file_size;
        logic [31:0] time_stamp;
    } frd_result_t;

    function automatic logic [7:0] ok_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'h2B;
            3'd1:    c = 8'h4F;
            3'd2:    c = 8'h4B;
            3'd3:    c = 8'h0D;
            3'd4:    c = 8'h0A;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] err_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'h2D;
            3'd1:    c = 8'h45;
            3'd2:    c = 8'h52;
            3'd3:    c = 8'h52;
            3'd4:    c = 8'h0D;
            3'd5:    c = 8'h0A;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

FILE: hw/rtl/frd_step.sv
// Per-item step logic of the file response deframer: next state and result for
// one input item. Purely combinational. Depends on frd_pkg.
module frd_step
    import frd_pkg::*;
(
    input  frd_state_t  cur,
    input  logic        opcode,
    input  logic [7:0]  rx_byte,
    output frd_state_t  nxt,
    output frd_result_t res
);

    logic        err_hit;
    logic        ok_hit;
    logic        dash_first;
    logic [31:0] acc_shift;
    logic [31:0] rem_dec;
    logic [2:0]  pos_inc;
    logic [1:0]  count_inc;

    assign err_hit    = (cur.match_pos < 3'(ERR_LEN)) && (rx_byte == err_char(cur.match_pos));
    assign ok_hit     = (cur.match_pos < 3'(OK_LEN)) && (rx_byte == ok_char(cur.match_pos));
    assign dash_first = (cur.match_pos == 3'd0) && (rx_byte == err_char(3'd0));
    assign acc_shift  = {cur.field_acc[23:0], rx_byte};
    assign rem_dec    = cur.remaining - 32'd1;
    assign pos_inc    = cur.match_pos + 3'd1;
    assign count_inc  = cur.field_count + 2'd1;

    always_comb
    begin
        nxt = cur;
        case (cur.phase)
            PH_IDLE, PH_OK, PH_SIZE, PH_STAMP, PH_PAYLOAD:
            begin
                if (opcode == OP_ARM)
                begin
                    nxt.phase       = PH_OK;
                    nxt.match_pos   = 3'd0;
                    nxt.field_count = 2'd0;
                end
                else
                begin
                    case (cur.phase)
                        PH_IDLE:
                        begin
                            if (!err_hit)
                                nxt.phase = PH_ERROR;
                            else if (pos_inc == 3'(ERR_LEN))
                                nxt.match_pos = 3'd0;
                            else
                                nxt.match_pos = pos_inc;
                        end
                        PH_OK:
                        begin
                            if (dash_first)
                            begin
                                nxt.phase     = PH_IDLE;
                                nxt.match_pos = 3'd1;
                            end
                            else if (!ok_hit)
                                nxt.phase = PH_ERROR;
                            else if (pos_inc == 3'(OK_LEN))
                            begin
                                nxt.match_pos   = 3'd0;
                                nxt.field_count = 2'd0;
                                nxt.phase       = PH_SIZE;
                            end
                            else
                                nxt.match_pos = pos_inc;
                        end
                        PH_SIZE, PH_STAMP:
                        begin
                            nxt.field_acc = acc_shift;
                            if (cur.field_count == 2'(FIELD_BYTES - 1))
                            begin
                                nxt.field_count = 2'd0;
                                if (cur.phase == PH_SIZE)
                                begin
                                    nxt.remaining = acc_shift;
                                    nxt.phase     = PH_STAMP;
                                end
                                else
                                begin
                                    nxt.size  = cur.remaining;
                                    nxt.stamp = acc_shift;
                                    if (cur.remaining == 32'd0)
                                    begin
                                        nxt.phase     = PH_IDLE;
                                        nxt.match_pos = 3'd0;
                                    end
                                    else
                                        nxt.phase = PH_PAYLOAD;
                                end
                            end
                            else
                                nxt.field_count = count_inc;
                        end
                        default:
                        begin
                            nxt.remaining = rem_dec;
                            if (rem_dec == 32'd0)
                            begin
                                nxt.phase     = PH_IDLE;
                                nxt.match_pos = 3'd0;
                            end
                        end
                    endcase
                end
            end
            default:
                nxt.phase = PH_ERROR;
        endcase
    end

    always_comb
    begin
        res.status       = ST_TAKEN;
        res.payload_byte = 8'd0;
        res.file_done    = 1'b0;
        res.file_size    = nxt.size;
        res.time_stamp   = nxt.stamp;
        case (cur.phase)
            PH_IDLE:
            begin
                if (opcode != OP_ARM)
                begin
                    if (!err_hit)
                        res.status = ST_PROTO;
                    else if (pos_inc == 3'(ERR_LEN))
                        res.status = ST_ERRDONE;
                end
            end
            PH_OK:
            begin
                if (opcode != OP_ARM && !dash_first && !ok_hit)
                    res.status = ST_PROTO;
            end
            PH_SIZE:
            begin
            end
            PH_STAMP:
            begin
                if (opcode != OP_ARM)
                    res.file_done = (cur.field_count == 2'(FIELD_BYTES - 1))
                                    && (cur.remaining == 32'd0);
            end
            PH_PAYLOAD:
            begin
                if (opcode != OP_ARM)
                begin
                    res.status       = ST_PAYLOAD;
                    res.payload_byte = rx_byte;
                    res.file_done    = (rem_dec == 32'd0);
                end
            end
            default:
                res.status = ST_PROTO;
        endcase
    end

endmodule

FILE: hw/rtl/file_response_deframer_core.sv
// File response deframer top level: state registers, step logic, result
// register with skid stage, and assertions. Depends on frd_pkg and frd_step.
//
// Usage:
//   Input channel (in_valid, in_stall, opcode, rx_byte): opcode 1 arms the
//   block after a request went out; opcode 0 carries one received byte.
//   Output channel (out_valid, out_stall, status, payload_byte, file_done,
//   file_size, time_stamp): exactly one result per accepted input item, in order.
//   The result of an accepted item is registered. Throughput: one item per cycle
//   while in_stall is low, set by the single registered pass through the step logic
//   that updates phase, counters and header regs.
//   When the receiver stalls, the result register holds and one more result
//   is captured in the skid register; in_stall rises while the skid register
//   is full and falls once the held result is taken.
//   Reset (rst_n low) returns the block to idle, clears match and field counters,
//   remaining count, file size, timestamp and the valid flags of both output stages.
//   A protocol error is sticky: every later item answers status 3 until reset.
module file_response_deframer_core
    import frd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        opcode,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [7:0]  payload_byte,
    output logic        file_done,
    output logic [31:0] file_size,
    output logic [31:0] time_stamp
);

    frd_state_t  state_reg;
    frd_state_t  state_next;
    frd_result_t step_res;
    frd_result_t out_res_reg;
    frd_result_t out_res_next;
    frd_result_t skid_res_reg;
    frd_result_t skid_res_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        skid_valid_reg;
    logic        skid_valid_next;
    logic        accept;
    logic        out_free;

    frd_step u_step (
        .cur     (state_reg),
        .opcode  (opcode),
        .rx_byte (rx_byte),
        .nxt     (state_next),
        .res     (step_res)
    );

    assign accept   = in_valid && !skid_valid_reg;
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = skid_valid_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_res_next    = out_res_reg;
        skid_res_next   = skid_res_reg;
        if (out_free)
        begin
            out_valid_next  = skid_valid_reg || accept;
            skid_valid_next = 1'b0;
            out_res_next    = skid_valid_reg ? skid_res_reg : step_res;
        end
        else if (accept)
        begin
            skid_valid_next = 1'b1;
            skid_res_next   = step_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                state_reg <= state_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg  <= out_res_next;
        skid_res_reg <= skid_res_next;
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_res_reg.status;
    assign payload_byte = out_res_reg.payload_byte;
    assign file_done    = out_res_reg.file_done;
    assign file_size    = out_res_reg.file_size;
    assign time_stamp   = out_res_reg.time_stamp;

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage full while result register empty");

    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase == PH_ERROR |=> state_reg.phase == PH_ERROR)
        else $error("error phase left before reset");

    a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_res_reg.status != ST_PAYLOAD |-> out_res_reg.payload_byte == 8'd0)
        else $error("payload byte set outside payload status");

    a_done_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_res_reg.file_done
            |-> out_res_reg.status == ST_TAKEN || out_res_reg.status == ST_PAYLOAD)
        else $error("file done with error status");

endmodule

FILE: verif/file_response_deframer_core_tb.sv
// Self-checking testbench for file_response_deframer_core: drives arm and byte items,
// predicts every result with its own deframer state and checks each field in order.
// Depends on frd_pkg and the RTL of file_response_deframer_core.
module file_response_deframer_core_tb;
    import frd_pkg::*;

    localparam logic        OP_BYTE        = ~OP_ARM;
    localparam logic [39:0] OK_MARK        = 40'h2B_4F_4B_0D_0A;
    localparam logic [47:0] ERR_MARK       = 48'h2D_45_52_52_0D_0A;
    localparam int unsigned IDLE_PCT       = 17;
    localparam int unsigned HOLD_CYCLES    = 300;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned ITEM_GOAL      = 1900;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        opcode;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic [7:0]  payload_byte;
    logic        file_done;
    logic [31:0] file_size;
    logic [31:0] time_stamp;

    phase_t      line_phase;
    logic [2:0]  mark_pos;
    logic [1:0]  hdr_count;
    logic [31:0] bytes_left;
    logic [31:0] shown_size;
    logic [31:0] shown_stamp;
    logic [31:0] hdr_shift;

    frd_result_t due_results[$];
    logic [8:0]  line_items[$];
    int unsigned items_sent;
    int unsigned fails;
    logic        steady;
    logic        hold_req;

    file_response_deframer_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .payload_byte (payload_byte),
        .file_done    (file_done),
        .file_size    (file_size),
        .time_stamp   (time_stamp)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [7:0] ok_at(input logic [2:0] pos);
        return OK_MARK[8 * (OK_LEN - 1 - pos) +: 8];
    endfunction

    function automatic logic [7:0] err_at(input logic [2:0] pos);
        return ERR_MARK[8 * (ERR_LEN - 1 - pos) +: 8];
    endfunction

    function automatic frd_result_t deframe_step(input logic op, input logic [7:0] b);
        frd_result_t r;
        r = '0;
        r.status = ST_TAKEN;
        if (line_phase == PH_ERROR)
        begin
            r.status = ST_PROTO;
        end
        else if (op == OP_ARM)
        begin
            line_phase = PH_OK;
            mark_pos   = 3'd0;
            hdr_count  = 2'd0;
        end
        else
        begin
            case (line_phase)
                PH_IDLE:
                begin
                    if (b == err_at(mark_pos))
                    begin
                        if (mark_pos == 3'(ERR_LEN - 1))
                        begin
                            mark_pos = 3'd0;
                            r.status = ST_ERRDONE;
                        end
                        else
                        begin
                            mark_pos = mark_pos + 3'd1;
                        end
                    end
                    else
                    begin
                        line_phase = PH_ERROR;
                        r.status   = ST_PROTO;
                    end
                end
                PH_OK:
                begin
                    if (mark_pos == 3'd0 && b == err_at(3'd0))
                    begin
                        line_phase = PH_IDLE;
                        mark_pos   = 3'd1;
                    end
                    else if (b == ok_at(mark_pos))
                    begin
                        if (mark_pos == 3'(OK_LEN - 1))
                        begin
                            mark_pos   = 3'd0;
                            hdr_count  = 2'd0;
                            line_phase = PH_SIZE;
                        end
                        else
                        begin
                            mark_pos = mark_pos + 3'd1;
                        end
                    end
                    else
                    begin
                        line_phase = PH_ERROR;
                        r.status   = ST_PROTO;
                    end
                end
                PH_SIZE, PH_STAMP:
                begin
                    hdr_shift = {hdr_shift[23:0], b};
                    if (hdr_count == 2'(FIELD_BYTES - 1))
                    begin
                        hdr_count = 2'd0;
                        if (line_phase == PH_SIZE)
                        begin
                            bytes_left = hdr_shift;
                            line_phase = PH_STAMP;
                        end
                        else
                        begin
                            shown_size  = bytes_left;
                            shown_stamp = hdr_shift;
                            if (bytes_left == 32'd0)
                            begin
                                r.file_done = 1'b1;
                                line_phase  = PH_IDLE;
                                mark_pos    = 3'd0;
                            end
                            else
                            begin
                                line_phase = PH_PAYLOAD;
                            end
                        end
                    end
                    else
                    begin
                        hdr_count = hdr_count + 2'd1;
                    end
                end
                default:
                begin
                    r.status       = ST_PAYLOAD;
                    r.payload_byte = b;
                    bytes_left     = bytes_left - 32'd1;
                    if (bytes_left == 32'd0)
                    begin
                        r.file_done = 1'b1;
                        line_phase  = PH_IDLE;
                        mark_pos    = 3'd0;
                    end
                end
            endcase
        end
        r.file_size  = shown_size;
        r.time_stamp = shown_stamp;
        return r;
    endfunction

    task automatic send_item(input logic op, input logic [7:0] b);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        rx_byte  <= b;
        do @(posedge clk); while (in_stall);
        due_results.push_back(deframe_step(op, b));
        items_sent++;
        @(negedge clk);
    endtask

    task automatic push_byte(input logic [7:0] b);
        line_items.push_back({OP_BYTE, b});
    endtask

    task automatic push_arm();
        line_items.push_back({OP_ARM, 8'($urandom_range(0, 255))});
    endtask

    task automatic push_ok();
        for (int i = 0; i < OK_LEN; i++)
            push_byte(ok_at(i[2:0]));
    endtask

    task automatic push_err();
        for (int i = 0; i < ERR_LEN; i++)
            push_byte(err_at(i[2:0]));
    endtask

    task automatic push_word(input logic [31:0] w);
        for (int i = 3; i >= 0; i--)
            push_byte(w[8 * i +: 8]);
    endtask

    task automatic send_line();
        foreach (line_items[i])
            send_item(line_items[i][8], line_items[i][7:0]);
        line_items.delete();
    endtask

    task automatic test_marker_cases();
        push_err();
        push_arm();
        push_err();
        send_line();
    endtask

    task automatic test_zero_size();
        push_arm();
        push_ok();
        push_word(32'd0);
        push_word(32'hFFFF_FFFF);
        send_line();
    endtask

    task automatic test_backpressure();
        hold_req = 1'b1;
        push_arm();
        push_ok();
        push_word(32'd40);
        push_word($urandom);
        for (int i = 0; i < 40; i++)
            push_byte(8'($urandom_range(0, 255)));
        send_line();
    endtask

    task automatic test_random_responses(input int unsigned goal);
        int unsigned pick;
        int unsigned size;
        int unsigned count;
        int unsigned cut;
        while (items_sent < goal)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 10 && line_phase == PH_IDLE && mark_pos == 3'd0)
            begin
                push_err();
            end
            else if (pick < 22)
            begin
                push_arm();
                push_err();
            end
            else if (pick < 27)
            begin
                push_arm();
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 65)
                    size = $urandom_range(0, 12);
                else if (pick < 85)
                    size = $urandom_range(13, 200);
                else
                    size = $urandom;
                count = (size > 200) ? 20 : size;
                push_arm();
                push_ok();
                push_word(size);
                push_word($urandom);
                for (int i = 0; i < count; i++)
                    push_byte(8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 99) < 15)
            begin
                cut = $urandom_range(1, line_items.size());
                while (line_items.size() > cut)
                    void'(line_items.pop_back());
            end
            send_line();
        end
    endtask

    task automatic test_full_rate();
        steady = 1'b1;
        test_random_responses(items_sent + 200);
        steady = 1'b0;
    endtask

    task automatic test_sticky_error();
        push_arm();
        push_byte(ok_at(3'd0));
        push_byte(ok_at(3'd1));
        push_byte(ok_at(3'd2));
        push_byte(ok_at(3'd3));
        push_byte(ok_at(3'd3));
        push_arm();
        push_byte(err_at(3'd0));
        push_byte(8'hFF);
        send_line();
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            fails++;
        end
    endtask

    initial
    begin : result_checker
        frd_result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (due_results.size() == 0)
                begin
                    $error("result with no item outstanding");
                    fails++;
                end
                else
                begin
                    want = due_results.pop_front();
                    check_field("status", 32'(want.status), 32'(status));
                    check_field("payload_byte", 32'(want.payload_byte),
                                32'(payload_byte));
                    check_field("file_done", 32'(want.file_done), 32'(file_done));
                    check_field("file_size", want.file_size, file_size);
                    check_field("time_stamp", want.time_stamp, time_stamp);
                end
            end
        end
    end

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    initial
    begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        opcode      = OP_BYTE;
        rx_byte     = 8'h00;
        steady      = 1'b0;
        hold_req    = 1'b0;
        fails       = 0;
        items_sent  = 0;
        line_phase  = PH_IDLE;
        mark_pos    = 3'd0;
        hdr_count   = 2'd0;
        bytes_left  = 32'd0;
        shown_size  = 32'd0;
        shown_stamp = 32'd0;
        hdr_shift   = 32'd0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_marker_cases();
        test_zero_size();
        test_backpressure();
        test_full_rate();
        test_random_responses(ITEM_GOAL - 10);
        test_sticky_error();

        in_valid <= 1'b0;
        while (due_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        if (fails == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
